FILE: hdl/bounded_double_ended_queue_macros.svh
// Assertion macros for the double-ended queue RTL.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define BDEQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define BDEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/bdeq_pkg.sv
// Types, constants and ring helpers for the double-ended queue.
package bdeq_pkg;

   localparam int DEPTH   = 64;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int SUM_W   = CNT_W + 1;
   localparam int DATA_W  = 32;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [DATA_W-1:0] data_type;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_LIST       = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ANSWER,
      ST_LIST
   } state_type;

   typedef struct packed {
      logic     wr_en;
      idx_type  wr_addr;
      data_type wr_data;
      logic     rd_en;
      idx_type  rd_addr;
   } mem_req_type;

   function automatic idx_type ring_inc(input idx_type pos);
      return (pos == IDX_W'(DEPTH - 1)) ? '0 : idx_type'(pos + 1'b1);
   endfunction

   function automatic idx_type ring_dec(input idx_type pos);
      return (pos == '0) ? IDX_W'(DEPTH - 1) : idx_type'(pos - 1'b1);
   endfunction

   // front + offset, wrapped; offset never exceeds DEPTH
   function automatic idx_type ring_add(input idx_type pos, input cnt_type offset);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(pos) + SUM_W'(offset);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

FILE: hdl/bdeq_ram.sv
// Ring store: one write port and one registered read port.
module bdeq_ram
   import bdeq_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output data_type    rd_data
);

   data_type mem [DEPTH];
   data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // hold read data until the next read so a stalled result stays put
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/bdeq_ctrl.sv
// Command sequencer: ring pointers, store accesses and the result register.
module bdeq_ctrl
   import bdeq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  data_type    req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output data_type    rsp_value,
   output status_type  rsp_status,
   output logic        rsp_last,
   output mem_req_type mem_req,
   input  data_type    rd_data
);

`include "bounded_double_ended_queue_macros.svh"

   localparam cnt_type MAX_COUNT = CNT_W'(DEPTH);

   state_type  state_ff, state_in;
   idx_type    front_ff, front_in;
   cnt_type    count_ff, count_in;
   status_type answer_status_ff, answer_status_in;
   logic       use_mem_ff, use_mem_in;
   idx_type    list_pos_ff, list_pos_in;
   cnt_type    list_left_ff, list_left_in;

   logic       rsp_valid_ff, rsp_valid_in;
   data_type   rsp_value_ff, rsp_value_in;
   status_type rsp_status_ff, rsp_status_in;
   logic       rsp_last_ff, rsp_last_in;

   logic req_fire;
   logic out_free;
   logic is_full;
   logic is_empty;
   logic push_ok;
   logic list_left_ok;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_full  = (count_ff == MAX_COUNT);
   assign is_empty = (count_ff == '0);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign push_ok      = req_fire && !is_full &&
                         (req_command == CMD_PUSH_BACK || req_command == CMD_PUSH_FRONT);
   assign list_left_ok = (list_left_ff != '0) && (list_left_ff <= count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      answer_status_ff <= answer_status_in;
      use_mem_ff       <= use_mem_in;
      list_pos_ff      <= list_pos_in;
      list_left_ff     <= list_left_in;
      rsp_value_ff     <= rsp_value_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_last_ff      <= rsp_last_in;
   end

   always_comb begin
      state_in         = state_ff;
      front_in         = front_ff;
      count_in         = count_ff;
      answer_status_in = answer_status_ff;
      use_mem_in       = use_mem_ff;
      list_pos_in      = list_pos_ff;
      list_left_in     = list_left_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_value_in     = rsp_value_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_last_in      = rsp_last_ff;
      mem_req          = '0;
      mem_req.wr_data  = req_value;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               answer_status_in = STATUS_OK;
               use_mem_in       = 1'b0;
               state_in         = ST_ANSWER;
               unique case (req_command)
                  CMD_PUSH_FRONT: begin
                     if (is_full) begin
                        answer_status_in = STATUS_FULL;
                     end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = ring_dec(front_ff);
                        front_in        = ring_dec(front_ff);
                        count_in        = count_ff + 1'b1;
                     end
                  end
                  CMD_PUSH_BACK: begin
                     if (is_full) begin
                        answer_status_in = STATUS_FULL;
                     end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = ring_add(front_ff, count_ff);
                        count_in        = count_ff + 1'b1;
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (is_empty) begin
                        answer_status_in = STATUS_EMPTY;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = front_ff;
                        use_mem_in      = 1'b1;
                        front_in        = ring_inc(front_ff);
                        count_in        = count_ff - 1'b1;
                     end
                  end
                  CMD_POP_BACK: begin
                     if (is_empty) begin
                        answer_status_in = STATUS_EMPTY;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = ring_add(front_ff, cnt_type'(count_ff - 1'b1));
                        use_mem_in      = 1'b1;
                        count_in        = count_ff - 1'b1;
                     end
                  end
                  CMD_LIST: begin
                     if (is_empty) begin
                        answer_status_in = STATUS_EMPTY;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = front_ff;
                        list_pos_in     = ring_inc(front_ff);
                        list_left_in    = count_ff;
                        state_in        = ST_LIST;
                     end
                  end
                  default: begin
                     // drop unused codes without a result
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ANSWER: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = use_mem_ff ? rd_data : '0;
               rsp_status_in = answer_status_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_LIST: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rd_data;
               rsp_status_in = STATUS_OK;
               rsp_last_in   = (list_left_ff == cnt_type'(1));
               if (list_left_ff == cnt_type'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  // fetch the next entry while this beat goes out
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = list_pos_ff;
                  list_pos_in     = ring_inc(list_pos_ff);
                  list_left_in    = list_left_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   `BDEQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= MAX_COUNT, "entry count above depth")
   `BDEQ_ASSERT_NOW(a_write_idle, mem_req.wr_en, req_ready && !mem_req.rd_en, "stray store write")
   `BDEQ_ASSERT_NOW(a_list_left, state_ff == ST_LIST, list_left_ok, "bad list run count")
   `BDEQ_ASSERT_NEXT(a_push_count, push_ok, count_ff == $past(count_ff) + 1'b1, "push count stuck")

endmodule

FILE: hdl/bounded_double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit values in a 64-entry ring store.
// One command is taken at a time. Push, pop and an empty or full answer pass
// through the answer state to the result beat, a pop's value coming from the
// store's registered read; req_tready returns once the result is in the output
// register, so a command can be taken while that result still waits. A list
// of N entries gives N beats after the first store read, one per cycle while
// rsp_tready is high, rsp_tlast on the last. The store needs no clearing at reset.
module bounded_double_ended_queue
   import bdeq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // [2:0] command, [34:3] value_in, [39:35] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [31:0] value_out, [33:32] status, [39:34] zero
   output logic        rsp_tlast
);

   mem_req_type mem_req;
   data_type    rd_data;
   data_type    rsp_value;
   status_type  rsp_status;

   bdeq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_command (req_tdata[2:0]),
      .req_value   (req_tdata[34:3]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_value   (rsp_value),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_tlast),
      .mem_req     (mem_req),
      .rd_data     (rd_data)
   );

   bdeq_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign rsp_tdata = {6'b0, rsp_status, rsp_value};

endmodule
